// ===== sv/cpsp_pkg.sv =====
package cpsp_pkg;

  // Field widths
  localparam int ANGLE_W    = 13;
  localparam int TURNS_W    = 11;
  localparam int SPEED_W    = 16;
  localparam int TARGET_W   = 32;
  localparam int GAIN_W     = 24;
  localparam int SETPT_W    = 13;
  localparam int CURRENT_W  = 15;
  localparam int INTEG_W    = 15;
  localparam int SPD_ERR_W  = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int FRAC_BITS  = 16;

  // Default encoder resolution
  localparam int COUNTS_PER_TURN_DEF = 8192;

  // Saturation limits
  localparam int POS_INT_LIM = 12000;
  localparam int SPD_SET_LIM = 3600;
  localparam int SPD_INT_LIM = 10800;
  localparam int CUR_LIM     = 10000;

  // Gain reset values, Q8.16
  localparam logic signed [GAIN_W-1:0] POS_P_RST = 24'sd7864;
  localparam logic signed [GAIN_W-1:0] POS_I_RST = 24'sd0;
  localparam logic signed [GAIN_W-1:0] POS_D_RST = 24'sd0;
  localparam logic signed [GAIN_W-1:0] SPD_P_RST = 24'sd655360;
  localparam logic signed [GAIN_W-1:0] SPD_I_RST = 24'sd19661;
  localparam logic signed [GAIN_W-1:0] SPD_D_RST = 24'sd0;

  typedef enum logic [1:0] {
    ACT_POS_TICK    = 2'd0,
    ACT_SPD_TICK    = 2'd1,
    ACT_LOAD_TARGET = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POS_P = 3'd0,
    REG_POS_I = 3'd1,
    REG_POS_D = 3'd2,
    REG_SPD_P = 3'd3,
    REG_SPD_I = 3'd4,
    REG_SPD_D = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [GAIN_W-1:0] p;
    logic signed [GAIN_W-1:0] i;
    logic signed [GAIN_W-1:0] d;
  } gains_t;

  typedef struct packed {
    logic [TARGET_W-1:0]        target;
    logic signed [INTEG_W-1:0]  integ;
    logic signed [TARGET_W-1:0] last_err;
  } pos_state_t;

  typedef struct packed {
    logic signed [INTEG_W-1:0]   integ;
    logic signed [SPD_ERR_W-1:0] last_err;
  } spd_state_t;

  // Width that holds both an angle and the half-turn reset value
  function automatic int prev_angle_w(input int cpt);
    int w;
    w = $clog2(cpt / 2 + 1);
    return (w > ANGLE_W) ? w : ANGLE_W;
  endfunction

endpackage

// ===== sv/cpsp_pos_loop.sv =====
module cpsp_pos_loop import cpsp_pkg::*; #(
  parameter int CountsPerTurn = COUNTS_PER_TURN_DEF
) (
  input  gains_t                                   gains_i,
  input  pos_state_t                               state_i,
  input  logic [prev_angle_w(CountsPerTurn)-1:0]   prev_angle_i,
  input  logic [ANGLE_W-1:0]                       angle_i,
  input  logic signed [TURNS_W-1:0]                turns_i,
  output pos_state_t                               state_o,
  output logic signed [SETPT_W-1:0]                setpoint_o
);

  localparam int QuarterLo = CountsPerTurn / 4;
  localparam int QuarterHi = CountsPerTurn / 4 * 3;

  logic [TARGET_W-1:0]          turn_add;
  logic [TARGET_W-1:0]          tgt_base;
  logic [TARGET_W-1:0]          tgt;
  logic [TARGET_W-1:0]          angle_ext;
  logic [TARGET_W-1:0]          prev_ext;
  logic signed [TARGET_W-1:0]   turns_ext;
  logic signed [TARGET_W-1:0]   err;
  logic signed [TARGET_W:0]     integ_sum;
  logic signed [INTEG_W-1:0]    integ;
  logic signed [TARGET_W:0]     diff;
  logic signed [55:0]           prod_p;
  logic signed [38:0]           prod_i;
  logic signed [56:0]           prod_d;
  logic signed [39:0]           term_p;
  logic signed [22:0]           term_i;
  logic signed [40:0]           term_d;
  logic signed [42:0]           sum;

  // Target update: whole turns plus zero-crossing unwrap
  always_comb begin
    turns_ext = TARGET_W'(turns_i);
    turn_add  = TARGET_W'(turns_ext * CountsPerTurn);
    tgt_base  = state_i.target + turn_add;
    angle_ext = TARGET_W'(angle_i);
    prev_ext  = TARGET_W'(prev_angle_i);
    if (angle_ext < TARGET_W'(QuarterLo) && prev_ext > TARGET_W'(QuarterHi)) begin
      tgt = tgt_base - TARGET_W'(CountsPerTurn);
    end else if (angle_ext > TARGET_W'(QuarterHi) && prev_ext < TARGET_W'(QuarterLo)) begin
      tgt = tgt_base + TARGET_W'(CountsPerTurn);
    end else begin
      tgt = tgt_base;
    end
  end

  // Error, clamped integral, derivative
  always_comb begin
    err       = signed'(tgt - angle_ext);
    integ_sum = (TARGET_W+1)'(err) + (TARGET_W+1)'(state_i.integ);
    if (integ_sum > (TARGET_W+1)'(POS_INT_LIM)) begin
      integ = INTEG_W'(POS_INT_LIM);
    end else if (integ_sum < -(TARGET_W+1)'(POS_INT_LIM)) begin
      integ = -INTEG_W'(POS_INT_LIM);
    end else begin
      integ = INTEG_W'(integ_sum);
    end
    diff = (TARGET_W+1)'(err) - (TARGET_W+1)'(state_i.last_err);
  end

  // Gain products, each truncated toward zero
  always_comb begin
    prod_p = gains_i.p * err;
    prod_i = gains_i.i * integ;
    prod_d = gains_i.d * diff;
    term_p = 40'((prod_p + (prod_p[55] ? 56'sd65535 : 56'sd0)) >>> FRAC_BITS);
    term_i = 23'((prod_i + (prod_i[38] ? 39'sd65535 : 39'sd0)) >>> FRAC_BITS);
    term_d = 41'((prod_d + (prod_d[56] ? 57'sd65535 : 57'sd0)) >>> FRAC_BITS);
    sum    = 43'(term_p) + 43'(term_i) + 43'(term_d);
  end

  // Setpoint saturation
  always_comb begin
    if (sum > 43'(SPD_SET_LIM)) begin
      setpoint_o = SETPT_W'(SPD_SET_LIM);
    end else if (sum < -43'(SPD_SET_LIM)) begin
      setpoint_o = -SETPT_W'(SPD_SET_LIM);
    end else begin
      setpoint_o = SETPT_W'(sum);
    end
    state_o.target   = tgt;
    state_o.integ    = integ;
    state_o.last_err = err;
  end

endmodule

// ===== sv/cpsp_spd_loop.sv =====
module cpsp_spd_loop import cpsp_pkg::*; (
  input  gains_t                      gains_i,
  input  spd_state_t                  state_i,
  input  logic signed [SETPT_W-1:0]   setpoint_i,
  input  logic signed [SPEED_W-1:0]   speed_i,
  output spd_state_t                  state_o,
  output logic signed [CURRENT_W-1:0] current_o
);

  logic signed [SPD_ERR_W-1:0] err;
  logic signed [SPD_ERR_W:0]   integ_sum;
  logic signed [INTEG_W-1:0]   integ;
  logic signed [SPD_ERR_W:0]   diff;
  logic signed [40:0]          prod_p;
  logic signed [38:0]          prod_i;
  logic signed [41:0]          prod_d;
  logic signed [24:0]          term_p;
  logic signed [22:0]          term_i;
  logic signed [25:0]          term_d;
  logic signed [27:0]          sum;

  // Error, clamped integral, derivative
  always_comb begin
    err       = SPD_ERR_W'(setpoint_i) - SPD_ERR_W'(speed_i);
    integ_sum = (SPD_ERR_W+1)'(err) + (SPD_ERR_W+1)'(state_i.integ);
    if (integ_sum > (SPD_ERR_W+1)'(SPD_INT_LIM)) begin
      integ = INTEG_W'(SPD_INT_LIM);
    end else if (integ_sum < -(SPD_ERR_W+1)'(SPD_INT_LIM)) begin
      integ = -INTEG_W'(SPD_INT_LIM);
    end else begin
      integ = INTEG_W'(integ_sum);
    end
    diff = (SPD_ERR_W+1)'(err) - (SPD_ERR_W+1)'(state_i.last_err);
  end

  // Gain products, each truncated toward zero
  always_comb begin
    prod_p = gains_i.p * err;
    prod_i = gains_i.i * integ;
    prod_d = gains_i.d * diff;
    term_p = 25'((prod_p + (prod_p[40] ? 41'sd65535 : 41'sd0)) >>> FRAC_BITS);
    term_i = 23'((prod_i + (prod_i[38] ? 39'sd65535 : 39'sd0)) >>> FRAC_BITS);
    term_d = 26'((prod_d + (prod_d[41] ? 42'sd65535 : 42'sd0)) >>> FRAC_BITS);
    sum    = 28'(term_p) + 28'(term_i) + 28'(term_d);
  end

  // Current saturation
  always_comb begin
    if (sum > 28'(CUR_LIM)) begin
      current_o = CURRENT_W'(CUR_LIM);
    end else if (sum < -28'(CUR_LIM)) begin
      current_o = -CURRENT_W'(CUR_LIM);
    end else begin
      current_o = CURRENT_W'(sum);
    end
    state_o.integ    = integ;
    state_o.last_err = err;
  end

endmodule

// ===== sv/cascaded_position_speed_pid.sv =====
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o  action, angle, turns, speed, target
// out       output     out_valid_o/out_stall_i speed_setpoint_out, current_command
// cfg       input      cfg_we_i               cfg_index_i, cfg_wdata_i
//
// One item per cycle while the result is not stalled; a result passes through the
// input register, then one compute pass into the state/result registers, and is
// valid once those registers are loaded.
// The loop state feeds straight back into the compute pass, so consecutive
// items see each other's updates with no bubble.
// Reset clears the loop state (previous angle to half a turn), restores
// default gains and empties the pipe.
// A stalled result holds the compute pass; the input register then stalls.
module cascaded_position_speed_pid import cpsp_pkg::*; #(
  parameter int COUNTS_PER_TURN = COUNTS_PER_TURN_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  action_i,
  input  logic [ANGLE_W-1:0]          measured_angle_i,
  input  logic signed [TURNS_W-1:0]   add_turns_i,
  input  logic signed [SPEED_W-1:0]   measured_speed_i,
  input  logic signed [TARGET_W-1:0]  new_target_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [SETPT_W-1:0]   speed_setpoint_out_o,
  output logic signed [CURRENT_W-1:0] current_command_o,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [GAIN_W-1:0]           cfg_wdata_i
);

  localparam int PrevW = prev_angle_w(COUNTS_PER_TURN);

  logic                        s1_valid_q, s1_valid_d;
  logic [1:0]                  action_q;
  logic [ANGLE_W-1:0]          angle_q;
  logic signed [TURNS_W-1:0]   turns_q;
  logic signed [SPEED_W-1:0]   speed_q;
  logic [TARGET_W-1:0]         new_target_q;
  logic                        res_valid_q, res_valid_d;
  logic                        advance;
  logic                        in_accept;

  gains_t                      pos_gains_q, spd_gains_q;
  pos_state_t                  pos_state_q, pos_state_d, pos_state_nx;
  spd_state_t                  spd_state_q, spd_state_d, spd_state_nx;
  logic [PrevW-1:0]            prev_angle_q, prev_angle_d;
  logic signed [SETPT_W-1:0]   setpoint_q, setpoint_d, setpoint_nx;
  logic signed [CURRENT_W-1:0] current_q, current_d, current_nx;

  // Handshake
  assign advance    = s1_valid_q && (!res_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_accept || (s1_valid_q && !advance);
  assign res_valid_d = advance || (res_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      action_q     <= action_i;
      angle_q      <= measured_angle_i;
      turns_q      <= add_turns_i;
      speed_q      <= measured_speed_i;
      new_target_q <= new_target_i;
    end
  end

  // Gain registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_gains_q <= '{p: POS_P_RST, i: POS_I_RST, d: POS_D_RST};
      spd_gains_q <= '{p: SPD_P_RST, i: SPD_I_RST, d: SPD_D_RST};
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_POS_P: pos_gains_q.p <= signed'(cfg_wdata_i);
        REG_POS_I: pos_gains_q.i <= signed'(cfg_wdata_i);
        REG_POS_D: pos_gains_q.d <= signed'(cfg_wdata_i);
        REG_SPD_P: spd_gains_q.p <= signed'(cfg_wdata_i);
        REG_SPD_I: spd_gains_q.i <= signed'(cfg_wdata_i);
        REG_SPD_D: spd_gains_q.d <= signed'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // Loop datapaths
  cpsp_pos_loop #(
    .CountsPerTurn(COUNTS_PER_TURN)
  ) u_pos_loop (
    .gains_i      (pos_gains_q),
    .state_i      (pos_state_q),
    .prev_angle_i (prev_angle_q),
    .angle_i      (angle_q),
    .turns_i      (turns_q),
    .state_o      (pos_state_nx),
    .setpoint_o   (setpoint_nx)
  );

  cpsp_spd_loop u_spd_loop (
    .gains_i    (spd_gains_q),
    .state_i    (spd_state_q),
    .setpoint_i (setpoint_q),
    .speed_i    (speed_q),
    .state_o    (spd_state_nx),
    .current_o  (current_nx)
  );

  // State update, selected by action
  always_comb begin
    pos_state_d  = pos_state_q;
    spd_state_d  = spd_state_q;
    prev_angle_d = prev_angle_q;
    setpoint_d   = setpoint_q;
    current_d    = current_q;
    if (advance) begin
      unique case (action_q)
        ACT_POS_TICK: begin
          pos_state_d  = pos_state_nx;
          prev_angle_d = PrevW'(angle_q);
          setpoint_d   = setpoint_nx;
        end
        ACT_SPD_TICK: begin
          spd_state_d = spd_state_nx;
          current_d   = current_nx;
        end
        ACT_LOAD_TARGET: begin
          pos_state_d.target = new_target_q;
        end
        default: ;
      endcase
    end
  end

  // Loop state; setpoint and current also serve as the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_state_q  <= '0;
      spd_state_q  <= '0;
      prev_angle_q <= PrevW'(COUNTS_PER_TURN / 2);
      setpoint_q   <= '0;
      current_q    <= '0;
    end else begin
      pos_state_q  <= pos_state_d;
      spd_state_q  <= spd_state_d;
      prev_angle_q <= prev_angle_d;
      setpoint_q   <= setpoint_d;
      current_q    <= current_d;
    end
  end

  assign out_valid_o          = res_valid_q;
  assign speed_setpoint_out_o = setpoint_q;
  assign current_command_o    = current_q;

  // Checks
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (setpoint_q <= SETPT_W'(SPD_SET_LIM) &&
                     setpoint_q >= -SETPT_W'(SPD_SET_LIM) &&
                     current_q <= CURRENT_W'(CUR_LIM) &&
                     current_q >= -CURRENT_W'(CUR_LIM)))
    else $error("result outside saturation limits");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (res_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");

  a_advance_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("computed item produced no result");

  a_integ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_state_q.integ <= INTEG_W'(POS_INT_LIM) &&
     pos_state_q.integ >= -INTEG_W'(POS_INT_LIM) &&
     spd_state_q.integ <= INTEG_W'(SPD_INT_LIM) &&
     spd_state_q.integ >= -INTEG_W'(SPD_INT_LIM)))
    else $error("integrator outside clamp range");

endmodule
